[design/kss_pkg.sv]
`timescale 1ns / 1ps

package kss_pkg;

    localparam int OP_W        = 1;
    localparam int KEY_IDX_W   = 6;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int SEG_W       = 7;
    localparam int KEY_COUNT_W = 7;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BEFORE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AFTER  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 4'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LAST,
        S_DIV,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_HINT_H,
        S_HINT_H1,
        S_HINT_H2,
        S_HINT_HM1,
        S_BS_MID,
        S_BS_LO,
        S_BS_HI,
        S_RESP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rem_status_t;

endpackage

[design/kss_if.sv]
`timescale 1ns / 1ps

interface kss_req_if;
    logic                                valid;
    logic                                ready;
    logic [kss_pkg::OP_W-1:0]            op;
    logic [kss_pkg::KEY_IDX_W-1:0]       key_index;
    logic signed [kss_pkg::TIME_W-1:0]   time_value;

    modport source (output valid, op, key_index, time_value, input ready);
    modport sink   (input valid, op, key_index, time_value, output ready);
endinterface

interface kss_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [kss_pkg::STATUS_W-1:0]     status;
    logic [kss_pkg::SEG_W-1:0]        segment;

    modport source (output valid, status, segment, input ready);
    modport sink   (input valid, status, segment, output ready);
endinterface

interface kss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kss_pkg::CFG_IDX_W-1:0]     index;
    logic [kss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/kss_ram.sv]
`timescale 1ns / 1ps

module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/kss_rem.sv]
`timescale 1ns / 1ps

// truncated signed remainder, one restoring step per cycle
module kss_rem #(
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [WIDTH-1:0]  dividend,
    input  logic signed [WIDTH-1:0]  divisor,
    output logic signed [WIDTH-1:0]  remainder,
    output kss_pkg::rem_status_t     status
);

    localparam int CNTW = $clog2(WIDTH + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic [WIDTH-1:0] dq_reg, dq_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic             neg_reg, neg_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] dvd_mag;
    logic [WIDTH-1:0] dsr_mag;

    assign dvd_mag = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign dsr_mag = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
    assign trial   = {rem_reg, dq_reg[WIDTH-1]};
    assign diff    = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(WIDTH);
            dq_next   = dvd_mag;
            dsr_next  = dsr_mag;
            rem_next  = '0;
            neg_next  = dividend[WIDTH-1];
        end
        else if (busy_reg)
        begin
            dq_next  = dq_reg << 1;
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign remainder   = neg_reg ? $signed(~rem_reg + 1'b1) : $signed(rem_reg);
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[design/keyframe_segment_search_core.sv]
`timescale 1ns / 1ps

// Keyframe segment search.
// req channel: op 0 writes time_value into key slot key_index, op 1 looks up
// time_value. Key writes give no response transaction.
// rsp channel: one transaction per lookup with status (inside / at or before
// first key / at or after last key) and segment.
// cfg channel: register 0 key_count, register 1 loop_enable; always ready.
// The user must write cfg only while the block is idle; the block itself
// does not enforce it.
// A lookup checks the time against the first key, then the last key, then the
// hint segment and its neighbors, and else runs a binary search. In loop mode
// a negative time or one at or after the last key is first wrapped through
// the bit-serial remainder unit.
// Every compare reads the key table through its single registered read port.
// One lookup is in flight at a time; req is ready only between lookups.
// The response sits in an output register; a stalled receiver holds the
// block in its final step until that register frees up.
// Reset clears the hint, sets key_count to 1 and loop_enable to 0; the key
// table is undefined until written.
module keyframe_segment_search_core #(
    parameter int MAX_KEYS  = 64,
    parameter int TIME_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    kss_req_if.sink      req,
    kss_rsp_if.source    rsp,
    kss_cfg_if.sink      cfg
);

    localparam int IW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int SW = IW + 2;
    localparam int TW = TIME_BITS;
    localparam int EB = (TIME_BITS < 32) ? TIME_BITS : 32;

    kss_pkg::state_t state_reg, state_next;

    logic signed [TW-1:0]  t_reg, t_next;
    logic [CW-1:0]         n_reg, n_next;
    logic [IW-1:0]         hint_reg, hint_next;
    logic signed [SW-1:0]  left_reg, left_next;
    logic signed [SW-1:0]  right_reg, right_next;
    logic [IW-1:0]         mid_reg, mid_next;
    logic [kss_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [kss_pkg::SEG_W-1:0]    res_seg_reg, res_seg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [kss_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [kss_pkg::SEG_W-1:0]    out_seg_reg, out_seg_next;
    logic [kss_pkg::KEY_COUNT_W-1:0] key_count_reg;
    logic                  loop_en_reg;

    logic signed [EB-1:0]  t_cut;
    logic signed [TW-1:0]  t_in;
    logic [31:0]           kc_ext;
    logic [31:0]           eff;
    logic [CW-1:0]         n_in;
    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [IW-1:0]         ram_raddr;
    logic [TW-1:0]         ram_rdata;
    logic signed [TW-1:0]  cmp_data;
    logic                  lt;
    logic                  eq;
    logic signed [SW-1:0]  mid_sum;
    logic [IW-1:0]         mid_calc;
    logic                  rem_start;
    logic signed [TW-1:0]  rem_value;
    kss_pkg::rem_status_t  rem_sts;
    logic                  hint_fits;
    logic                  hint_two_fits;
    logic                  write_ok;

    assign t_cut     = req.time_value[EB-1:0];
    assign t_in      = TW'(t_cut);
    assign kc_ext    = 32'(key_count_reg);
    assign eff       = (kc_ext == 32'd0) ? 32'd1
                     : ((kc_ext > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : kc_ext);
    assign n_in      = eff[CW-1:0];
    assign ram_waddr = IW'(req.key_index);
    assign write_ok  = 32'(req.key_index) < 32'(MAX_KEYS);

    // shared compare unit: query time against the key just read
    assign cmp_data = $signed(ram_rdata);
    assign lt       = t_reg < cmp_data;
    assign eq       = t_reg == cmp_data;

    assign mid_sum       = left_reg + right_reg;
    assign mid_calc      = mid_sum[IW:1];
    assign hint_fits     = (32'(hint_reg) + 32'd2) <= 32'(n_reg);
    assign hint_two_fits = (32'(hint_reg) + 32'd2) < 32'(n_reg);

    kss_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (t_in),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kss_rem #(
        .WIDTH (TW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (t_reg),
        .divisor   (cmp_data),
        .remainder (rem_value),
        .status    (rem_sts)
    );

    always_comb
    begin
        state_next      = state_reg;
        t_next          = t_reg;
        n_next          = n_reg;
        hint_next       = hint_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        mid_next        = mid_reg;
        res_status_next = res_status_reg;
        res_seg_next    = res_seg_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_seg_next    = out_seg_reg;
        ram_we          = 1'b0;
        ram_raddr       = '0;
        rem_start       = 1'b0;

        case (state_reg)
            kss_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.op == kss_pkg::OP_WRITE)
                    begin
                        if (write_ok)
                        begin
                            ram_we    = 1'b1;
                            hint_next = '0;
                        end
                    end
                    else
                    begin
                        t_next     = t_in;
                        n_next     = n_in;
                        ram_raddr  = IW'(n_in - CW'(1));
                        state_next = kss_pkg::S_RD_LAST;
                    end
                end
            end
            kss_pkg::S_RD_LAST:
            begin
                if (loop_en_reg && (t_reg < 0 || !lt) && ram_rdata != '0)
                begin
                    rem_start  = 1'b1;
                    state_next = kss_pkg::S_DIV;
                end
                else
                begin
                    state_next = kss_pkg::S_CHK_FIRST;
                end
            end
            kss_pkg::S_DIV:
            begin
                if (rem_sts.done)
                begin
                    t_next     = rem_value;
                    state_next = kss_pkg::S_CHK_FIRST;
                end
            end
            kss_pkg::S_CHK_FIRST:
            begin
                if (n_reg == CW'(1) || lt || eq)
                begin
                    res_status_next = kss_pkg::ST_BEFORE;
                    res_seg_next    = '0;
                    state_next      = kss_pkg::S_RESP;
                end
                else
                begin
                    ram_raddr  = IW'(n_reg - CW'(1));
                    state_next = kss_pkg::S_CHK_LAST;
                end
            end
            kss_pkg::S_CHK_LAST:
            begin
                if (!lt)
                begin
                    res_status_next = kss_pkg::ST_AFTER;
                    res_seg_next    = kss_pkg::SEG_W'(n_reg);
                    state_next      = kss_pkg::S_RESP;
                end
                else
                begin
                    res_status_next = kss_pkg::ST_INSIDE;
                    if (hint_fits)
                    begin
                        ram_raddr  = hint_reg;
                        state_next = kss_pkg::S_HINT_H;
                    end
                    else
                    begin
                        left_next  = '0;
                        right_next = SW'(n_reg) - SW'(2);
                        mid_next   = '0;
                        state_next = kss_pkg::S_BS_MID;
                    end
                end
            end
            kss_pkg::S_HINT_H:
            begin
                if (!lt)
                begin
                    ram_raddr  = hint_reg + IW'(1);
                    state_next = kss_pkg::S_HINT_H1;
                end
                else if (hint_reg != '0)
                begin
                    ram_raddr  = hint_reg - IW'(1);
                    state_next = kss_pkg::S_HINT_HM1;
                end
                else
                begin
                    left_next  = '0;
                    right_next = SW'(n_reg) - SW'(2);
                    mid_next   = '0;
                    state_next = kss_pkg::S_BS_MID;
                end
            end
            kss_pkg::S_HINT_H1:
            begin
                if (lt)
                begin
                    res_seg_next = kss_pkg::SEG_W'(hint_reg);
                    state_next   = kss_pkg::S_RESP;
                end
                else if (hint_two_fits)
                begin
                    ram_raddr  = hint_reg + IW'(2);
                    state_next = kss_pkg::S_HINT_H2;
                end
                else
                begin
                    left_next  = '0;
                    right_next = SW'(n_reg) - SW'(2);
                    mid_next   = '0;
                    state_next = kss_pkg::S_BS_MID;
                end
            end
            kss_pkg::S_HINT_H2:
            begin
                if (lt)
                begin
                    hint_next    = hint_reg + IW'(1);
                    res_seg_next = kss_pkg::SEG_W'(hint_reg + IW'(1));
                    state_next   = kss_pkg::S_RESP;
                end
                else
                begin
                    left_next  = '0;
                    right_next = SW'(n_reg) - SW'(2);
                    mid_next   = '0;
                    state_next = kss_pkg::S_BS_MID;
                end
            end
            kss_pkg::S_HINT_HM1:
            begin
                if (!lt)
                begin
                    hint_next    = hint_reg - IW'(1);
                    res_seg_next = kss_pkg::SEG_W'(hint_reg - IW'(1));
                    state_next   = kss_pkg::S_RESP;
                end
                else
                begin
                    left_next  = '0;
                    right_next = SW'(n_reg) - SW'(2);
                    mid_next   = '0;
                    state_next = kss_pkg::S_BS_MID;
                end
            end
            kss_pkg::S_BS_MID:
            begin
                if (left_reg <= right_reg)
                begin
                    mid_next   = mid_calc;
                    ram_raddr  = mid_calc;
                    state_next = kss_pkg::S_BS_LO;
                end
                else
                begin
                    hint_next    = mid_reg;
                    res_seg_next = kss_pkg::SEG_W'(mid_reg);
                    state_next   = kss_pkg::S_RESP;
                end
            end
            kss_pkg::S_BS_LO:
            begin
                if (lt)
                begin
                    right_next = SW'(mid_reg) - SW'(1);
                    state_next = kss_pkg::S_BS_MID;
                end
                else
                begin
                    ram_raddr  = mid_reg + IW'(1);
                    state_next = kss_pkg::S_BS_HI;
                end
            end
            kss_pkg::S_BS_HI:
            begin
                if (!lt)
                begin
                    left_next  = SW'(mid_reg) + SW'(1);
                    state_next = kss_pkg::S_BS_MID;
                end
                else
                begin
                    hint_next    = mid_reg;
                    res_seg_next = kss_pkg::SEG_W'(mid_reg);
                    state_next   = kss_pkg::S_RESP;
                end
            end
            kss_pkg::S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_seg_next    = res_seg_reg;
                    state_next      = kss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kss_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kss_pkg::S_IDLE;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
            key_count_reg <= kss_pkg::KEY_COUNT_W'(1);
            loop_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    kss_pkg::REG_KEY_COUNT:
                    begin
                        key_count_reg <= cfg.data[kss_pkg::KEY_COUNT_W-1:0];
                    end
                    kss_pkg::REG_LOOP_ENABLE:
                    begin
                        loop_en_reg <= cfg.data[0];
                    end
                    default:
                    begin
                        loop_en_reg <= loop_en_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        n_reg          <= n_next;
        left_reg       <= left_next;
        right_reg      <= right_next;
        mid_reg        <= mid_next;
        res_status_reg <= res_status_next;
        res_seg_reg    <= res_seg_next;
        out_status_reg <= out_status_next;
        out_seg_reg    <= out_seg_next;
    end

    assign req.ready   = (state_reg == kss_pkg::S_IDLE);
    assign cfg.ready   = 1'b1;
    assign rsp.valid   = out_valid_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.segment = out_seg_reg;

    a_write_clears_hint: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == kss_pkg::OP_WRITE && write_ok)
        |=> hint_reg == '0)
        else $error("key write did not clear the hint");

    a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == kss_pkg::OP_LOOKUP)
        |=> state_reg == kss_pkg::S_RD_LAST)
        else $error("lookup did not start with the last key read");

    a_hint_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hint_reg) <= 32'(MAX_KEYS - 2))
        else $error("hint beyond last segment");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.status == kss_pkg::ST_INSIDE
                       || rsp.status == kss_pkg::ST_BEFORE
                       || rsp.status == kss_pkg::ST_AFTER))
        else $error("undefined status code");

    a_before_seg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == kss_pkg::ST_BEFORE) |-> rsp.segment == '0)
        else $error("before-first-key response with nonzero segment");

endmodule
